/* design/hpc_pkg.sv */
// Package for the hood position PI controller.
// Holds the widths, command and register codes, and fixed-point constants.
// No dependencies.
package hpc_pkg;

  localparam int ACC_W      = 40;
  localparam int GAIN_W     = 24;
  localparam int ANGLE_W    = 16;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = 18;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int LO_W       = ACC_W / 2;
  localparam int HI_W       = ACC_W - LO_W;
  localparam int PROD_W     = ACC_W + GAIN_W;
  localparam int PROP_W     = ERR_W + GAIN_W;
  localparam int CLIP_SHIFT = 48;
  localparam int TERM_W     = (PROD_W > CLIP_SHIFT + 1) ? PROD_W : CLIP_SHIFT + 1;
  localparam int SUM_W      = TERM_W + 2;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = SUM_W - FRAC_W;

  localparam int DRIVE_MAX  = 32767;

  localparam logic [1:0] CMD_TRACK  = 2'd0;
  localparam logic [1:0] CMD_MANUAL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 2'd2;

  localparam logic signed [ANGLE_W-1:0] TARGET_MIN = 16'sd1000;
  localparam logic signed [ANGLE_W-1:0] TARGET_MAX = 16'sd9000;
  localparam logic signed [ANGLE_W-1:0] SLOW_LOW   = 16'sd2500;
  localparam logic signed [ANGLE_W-1:0] STOP_HIGH  = 16'sd9000;
  localparam logic signed [ANGLE_W-1:0] SLOW_HIGH  = 16'sd8100;

  localparam logic signed [ERR_W-1:0]  IZONE    = 18'sd500;
  localparam logic signed [ERR_W-1:0]  DEADBAND = 18'sd30;
  localparam logic signed [STEP_W-1:0] ISTEP    = 24'sd50;

  localparam logic signed [DRIVE_W-1:0] LOCK_THRESH = 16'sd1638;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LIM   = DRIVE_W'(DRIVE_MAX);
  localparam logic signed [DRIVE_W-1:0] DRIVE_NEG   = {1'b1, {(DRIVE_W - 1){1'b0}}};

  // Division by five as a multiply by ceil(2^18 / 5), exact below 2^18.
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

endpackage

/* design/hood_position_pi_controller.sv */
// Hood position PI controller with lock deadband and soft limits.
// Depends on hpc_pkg.
//
// One item is taken per clock cycle while in_stall is low, and each passes
// through five register stages: input register, measurement and integrator
// update, gain multiplies, term clipping and drive saturation, then soft
// limits into the output register. The integrator is updated in the single
// cycle an item leaves the input register, which sets the one-item-per-cycle
// rate. A stall on the output only holds stages that are occupied, so bubbles
// keep closing and new transfers are taken while a result waits. Configuration
// writes take effect on the next clock edge.
module hood_position_pi_controller
  import hpc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic signed [ANGLE_W-1:0]    target_angle,
  input  logic signed [ANGLE_W-1:0]    encoder_angle,
  input  logic                         zero_switch_pressed,
  input  logic signed [DRIVE_W-1:0]    manual_drive,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DRIVE_W-1:0]    motor_drive,
  output logic                         hood_locked,
  output logic signed [ANGLE_W-1:0]    hood_angle
);

  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic signed [ANGLE_W-1:0] angle_offset;
  logic signed [ACC_W-1:0]   integrator;

  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s2_ready, s3_ready, s4_ready, out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign s4_ready  = !s4_valid || out_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign in_stall  = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      angle_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:    prop_gain    <= cfg_data;
        REG_INTEG_GAIN:   integ_gain   <= cfg_data;
        REG_ANGLE_OFFSET: angle_offset <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: input register.
  logic [1:0]                s1_cmd;
  logic signed [ANGLE_W-1:0] s1_target;
  logic signed [ANGLE_W-1:0] s1_enc;
  logic                      s1_pressed;
  logic signed [DRIVE_W-1:0] s1_manual;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_cmd     <= command;
      s1_target  <= target_angle;
      s1_enc     <= encoder_angle;
      s1_pressed <= zero_switch_pressed;
      s1_manual  <= manual_drive;
    end
  end

  // Measurement, error and integrator update.
  logic signed [ANGLE_W:0]   ang_sum;
  logic signed [ANGLE_W-1:0] ang;
  logic signed [ANGLE_W-1:0] tgt;
  logic signed [ERR_W-1:0]   err;
  logic signed [STEP_W-1:0]  step;
  logic signed [ACC_W:0]     integ_add;
  logic signed [ACC_W-1:0]   integ_sat;
  logic signed [ACC_W-1:0]   integ_next;
  logic                      in_zone;
  logic                      in_deadband;
  logic signed [DRIVE_W-1:0] manual_sat;
  logic signed [DRIVE_W-1:0] pass_drive;

  always_comb begin
    if (s1_pressed) begin
      ang_sum = {angle_offset[ANGLE_W-1], angle_offset};
    end else begin
      ang_sum = {s1_enc[ANGLE_W-1], s1_enc} + {angle_offset[ANGLE_W-1], angle_offset};
    end
    if (ang_sum[ANGLE_W] != ang_sum[ANGLE_W-1]) begin
      ang = ang_sum[ANGLE_W] ? {1'b1, {(ANGLE_W - 1){1'b0}}} : {1'b0, {(ANGLE_W - 1){1'b1}}};
    end else begin
      ang = ang_sum[ANGLE_W-1:0];
    end

    if (s1_target < TARGET_MIN) begin
      tgt = TARGET_MIN;
    end else if (s1_target > TARGET_MAX) begin
      tgt = TARGET_MAX;
    end else begin
      tgt = s1_target;
    end

    err = {{(ERR_W - ANGLE_W){ang[ANGLE_W-1]}}, ang}
        - {{(ERR_W - ANGLE_W){tgt[ANGLE_W-1]}}, tgt};
    in_zone     = (err < IZONE) && (err > -IZONE);
    in_deadband = (err <= DEADBAND) && (err >= -DEADBAND);

    step = {{(STEP_W - ERR_W){err[ERR_W-1]}}, err} * ISTEP;
    integ_add = {integrator[ACC_W-1], integrator}
              + {{(ACC_W + 1 - STEP_W){step[STEP_W-1]}}, step};
    if (integ_add[ACC_W] != integ_add[ACC_W-1]) begin
      integ_sat = integ_add[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                   : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      integ_sat = integ_add[ACC_W-1:0];
    end

    case (s1_cmd)
      CMD_TRACK:  integ_next = (in_zone && !in_deadband) ? integ_sat : '0;
      CMD_CLEAR:  integ_next = '0;
      default:    integ_next = integrator;
    endcase

    manual_sat = (s1_manual == DRIVE_NEG) ? -DRIVE_LIM : s1_manual;
    pass_drive = (s1_cmd == CMD_MANUAL) ? manual_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (s1_valid && s2_ready) begin
      integrator <= integ_next;
    end
  end

  // Stage 2: error and updated integrator.
  logic                      s2_pi_en;
  logic signed [DRIVE_W-1:0] s2_pass;
  logic signed [ANGLE_W-1:0] s2_ang;
  logic                      s2_pressed;
  logic signed [ERR_W-1:0]   s2_err;
  logic signed [ACC_W-1:0]   s2_integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_pi_en   <= (s1_cmd == CMD_TRACK) && !in_deadband;
      s2_pass    <= pass_drive;
      s2_ang     <= ang;
      s2_pressed <= s1_pressed;
      s2_err     <= err;
      s2_integ   <= integ_next;
    end
  end

  // Gain multiplies on magnitudes; the integrator product is split in two halves.
  logic [ERR_W-1:0]         err_mag;
  logic [ACC_W-1:0]         integ_mag;
  logic [PROP_W-1:0]        prop_prod;
  logic [LO_W+GAIN_W-1:0]   lo_prod;
  logic [HI_W+GAIN_W-1:0]   hi_prod;

  always_comb begin
    err_mag   = s2_err[ERR_W-1] ? ERR_W'(-s2_err) : ERR_W'(s2_err);
    integ_mag = s2_integ[ACC_W-1] ? ACC_W'(-s2_integ) : ACC_W'(s2_integ);
    prop_prod = PROP_W'(err_mag) * PROP_W'(prop_gain);
    lo_prod   = (LO_W + GAIN_W)'(integ_mag[LO_W-1:0]) * (LO_W + GAIN_W)'(integ_gain);
    hi_prod   = (HI_W + GAIN_W)'(integ_mag[ACC_W-1:LO_W]) * (HI_W + GAIN_W)'(integ_gain);
  end

  // Stage 3: partial products.
  logic                      s3_pi_en;
  logic signed [DRIVE_W-1:0] s3_pass;
  logic signed [ANGLE_W-1:0] s3_ang;
  logic                      s3_pressed;
  logic                      s3_err_neg;
  logic                      s3_integ_neg;
  logic [PROP_W-1:0]         s3_prop;
  logic [LO_W+GAIN_W-1:0]    s3_lo;
  logic [HI_W+GAIN_W-1:0]    s3_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_pi_en     <= s2_pi_en;
      s3_pass      <= s2_pass;
      s3_ang       <= s2_ang;
      s3_pressed   <= s2_pressed;
      s3_err_neg   <= s2_err[ERR_W-1];
      s3_integ_neg <= s2_integ[ACC_W-1];
      s3_prop      <= prop_prod;
      s3_lo        <= lo_prod;
      s3_hi        <= hi_prod;
    end
  end

  // Clip the integral term, sum, floor-divide by 2^16 and saturate.
  localparam logic [TERM_W-1:0]       CLIP_LIMIT = TERM_W'(1) << CLIP_SHIFT;
  localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(DRIVE_MAX);

  logic [PROD_W-1:0]         integ_prod;
  logic [TERM_W-1:0]         integ_clip;
  logic signed [SUM_W-1:0]   prop_ext;
  logic signed [SUM_W-1:0]   integ_ext;
  logic signed [SUM_W-1:0]   raw;
  logic signed [Q_W-1:0]     q;
  logic signed [DRIVE_W-1:0] pi_drive;
  logic signed [DRIVE_W-1:0] pre_drive;

  always_comb begin
    integ_prod = (PROD_W'(s3_hi) << LO_W) + PROD_W'(s3_lo);
    integ_clip = (TERM_W'(integ_prod) > CLIP_LIMIT) ? CLIP_LIMIT : TERM_W'(integ_prod);
    prop_ext   = SUM_W'(s3_prop);
    integ_ext  = SUM_W'(integ_clip);
    raw = (s3_err_neg ? prop_ext : -prop_ext) + (s3_integ_neg ? integ_ext : -integ_ext);
    q   = raw[SUM_W-1:FRAC_W];
    if (q > Q_MAX) begin
      pi_drive = DRIVE_LIM;
    end else if (q < -Q_MAX) begin
      pi_drive = -DRIVE_LIM;
    end else begin
      pi_drive = q[DRIVE_W-1:0];
    end
    pre_drive = s3_pi_en ? pi_drive : s3_pass;
  end

  // Stage 4: drive before the lock and soft limits.
  logic signed [DRIVE_W-1:0] s4_drive;
  logic signed [ANGLE_W-1:0] s4_ang;
  logic                      s4_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_drive   <= pre_drive;
      s4_ang     <= s3_ang;
      s4_pressed <= s3_pressed;
    end
  end

  logic                      lock;
  logic                      drive_neg;
  logic [DRIVE_W-1:0]        drive_mag;
  logic [DRIVE_W:0]          mag2;
  logic [2*DRIVE_W:0]        div_prod;
  logic [DRIVE_W-1:0]        slow_mag;
  logic signed [DRIVE_W-1:0] slow_drive;
  logic signed [DRIVE_W-1:0] limited;

  always_comb begin
    lock       = (s4_drive <= LOCK_THRESH) && (s4_drive >= -LOCK_THRESH);
    drive_neg  = s4_drive[DRIVE_W-1];
    drive_mag  = drive_neg ? DRIVE_W'(-s4_drive) : DRIVE_W'(s4_drive);
    mag2       = {drive_mag, 1'b0};
    div_prod   = (2 * DRIVE_W + 1)'(mag2) * (2 * DRIVE_W + 1)'(DIV5_MUL);
    slow_mag   = DRIVE_W'(div_prod >> DIV5_SHIFT);
    slow_drive = drive_neg ? -$signed(slow_mag) : $signed(slow_mag);
    if (lock) begin
      limited = '0;
    end else if (s4_pressed && drive_neg) begin
      limited = '0;
    end else if ((s4_ang < SLOW_LOW) && drive_neg) begin
      limited = slow_drive;
    end else if ((s4_ang > STOP_HIGH) && !drive_neg) begin
      limited = '0;
    end else if ((s4_ang > SLOW_HIGH) && !drive_neg) begin
      limited = slow_drive;
    end else begin
      limited = s4_drive;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      motor_drive <= limited;
      hood_locked <= lock;
      hood_angle  <= s4_ang;
    end
  end

endmodule

/* design/hpc_checker.sv */
// Port-level checks for the hood position PI controller, bound to the top level.
// Depends on hpc_pkg and hood_position_pi_controller.
module hpc_checker
  import hpc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DRIVE_W-1:0] motor_drive,
  input logic                      hood_locked,
  input logic signed [ANGLE_W-1:0] hood_angle
);

  // A stalled result stays offered with its drive and angle unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_drive) && $stable(hood_angle))
    else $error("stalled result changed or was dropped");

  // A locked hood never gets a drive.
  a_lock_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hood_locked |-> motor_drive == '0)
    else $error("drive present while the lock is engaged");

  // The drive is symmetric and never reaches the most negative code.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_drive != DRIVE_NEG)
    else $error("drive outside its symmetric range");

  // With the output register empty, every stage can advance, so input is open.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // A transfer offered while the output register is empty is never answered by a stall.
  a_accept_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> !in_stall)
    else $error("input transfer refused with the pipeline draining");

endmodule

bind hood_position_pi_controller hpc_checker u_hpc_checker (.*);
